// ===== sv/frcc_pkg.sv =====
// Shared types, constants and byte classification for the FASTA composition counter.
`timescale 1ns / 1ps

package frcc_pkg;

  localparam logic [7:0] HDR_MARK = 8'h3E;
  localparam logic [7:0] NEWLINE  = 8'h0A;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);

  localparam logic [1:0] CLS_GC   = 2'd0;
  localparam logic [1:0] CLS_AT   = 2'd1;
  localparam logic [1:0] CLS_AMB  = 2'd2;
  localparam logic [1:0] CLS_ANOM = 2'd3;

  localparam logic [1:0] OP_HDR   = 2'd0;
  localparam logic [1:0] OP_SEQ   = 2'd1;
  localparam logic [1:0] OP_OPEN  = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] cls;
    logic       emit;
  } op_t;

  typedef struct packed {
    logic [15:0] record_index;
    logic [31:0] seq_length;
    logic [31:0] gc_count;
    logic [31:0] at_count;
    logic [31:0] ambiguous_count;
    logic [31:0] anomalous_count;
    logic [31:0] header_length;
    logic [31:0] min_length;
    logic [31:0] max_length;
    logic [31:0] min_ambiguous;
    logic [31:0] max_ambiguous;
  } res_t;

  function automatic logic [1:0] classify(input logic [7:0] b);
    logic [7:0] u;
    logic [1:0] c;
    u = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      u = b - 8'h20;
    end
    if (u inside {8'h43, 8'h47}) begin
      c = CLS_GC;
    end else if (u inside {8'h41, 8'h54}) begin
      c = CLS_AT;
    end else if (u inside {8'h52, 8'h59, 8'h4B, 8'h4D, 8'h53, 8'h57,
                           8'h42, 8'h44, 8'h48, 8'h56, 8'h4E}) begin
      c = CLS_AMB;
    end else if (b == 8'h2D) begin
      c = CLS_AMB;
    end else begin
      c = CLS_ANOM;
    end
    return c;
  endfunction

endpackage

// ===== sv/frcc_front.sv =====
// Front end: tracks line and record state and turns bytes into counter operations.
`timescale 1ns / 1ps

module frcc_front
  import frcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       mode,
  input  logic [7:0] data_byte,
  output logic       op_valid,
  output op_t        op
);

  logic in_header;
  logic at_line_start;
  logic record_open;
  logic in_header_next;
  logic at_line_start_next;
  logic record_open_next;

  always_comb begin
    in_header_next     = in_header;
    at_line_start_next = at_line_start;
    record_open_next   = record_open;
    op_valid           = 1'b0;
    op.kind            = OP_HDR;
    op.cls             = classify(data_byte);
    op.emit            = 1'b0;
    if (mode) begin
      op_valid           = accept && record_open;
      op.kind            = OP_CLOSE;
      op.emit            = 1'b1;
      record_open_next   = 1'b0;
      in_header_next     = 1'b0;
      at_line_start_next = 1'b1;
    end else if (data_byte == NEWLINE) begin
      in_header_next     = 1'b0;
      at_line_start_next = 1'b1;
    end else if (at_line_start && data_byte == HDR_MARK) begin
      op_valid           = accept;
      op.kind            = OP_OPEN;
      op.emit            = record_open;
      record_open_next   = 1'b1;
      in_header_next     = 1'b1;
      at_line_start_next = 1'b0;
    end else begin
      at_line_start_next = 1'b0;
      if (in_header) begin
        op_valid = accept;
        op.kind  = OP_HDR;
      end else begin
        op_valid = accept && record_open;
        op.kind  = OP_SEQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header     <= 1'b0;
      at_line_start <= 1'b1;
      record_open   <= 1'b0;
    end else if (accept) begin
      in_header     <= in_header_next;
      at_line_start <= at_line_start_next;
      record_open   <= record_open_next;
    end
  end

endmodule

// ===== sv/frcc_opq.sv =====
// Short operation queue between the front end and the counter back end.
`timescale 1ns / 1ps

module frcc_opq
  import frcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output op_t  rd_op
);

  op_t                  mem [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr;
  logic [OPQ_PTR_W-1:0] rd_ptr;
  logic [OPQ_PTR_W:0]   count;

  assign full  = (count == (OPQ_PTR_W+1)'(OPQ_DEPTH));
  assign empty = (count == '0);
  assign rd_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + OPQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + OPQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (OPQ_PTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (OPQ_PTR_W+1)'(1);
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (OPQ_PTR_W+1)'(OPQ_DEPTH))
    else $error("op queue count beyond depth");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && empty))
    else $error("op queue read while empty");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full && !rd_en))
    else $error("op queue written while full");

endmodule

// ===== sv/frcc_back.sv =====
// Back end: saturating tallies, running extremes and the result register.
`timescale 1ns / 1ps

module frcc_back
  import frcc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int INDEX_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  op_t  q_op,
  output logic q_rd,
  input  logic pop,
  output logic empty,
  output res_t res
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [INDEX_WIDTH-1:0] record_number;
  logic [COUNT_WIDTH-1:0] length_count;
  logic [COUNT_WIDTH-1:0] gc_tally;
  logic [COUNT_WIDTH-1:0] at_tally;
  logic [COUNT_WIDTH-1:0] ambiguous_tally;
  logic [COUNT_WIDTH-1:0] anomalous_tally;
  logic [COUNT_WIDTH-1:0] header_tally;
  logic [COUNT_WIDTH-1:0] shortest_length;
  logic [COUNT_WIDTH-1:0] longest_length;
  logic [COUNT_WIDTH-1:0] fewest_ambiguous;
  logic [COUNT_WIDTH-1:0] most_ambiguous;
  logic [COUNT_WIDTH-1:0] shortest_length_next;
  logic [COUNT_WIDTH-1:0] longest_length_next;
  logic [COUNT_WIDTH-1:0] fewest_ambiguous_next;
  logic [COUNT_WIDTH-1:0] most_ambiguous_next;
  logic                   out_valid;
  logic                   out_accept;
  logic                   emit_fire;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign out_accept = pop && out_valid;
  assign q_rd       = !q_empty && (!q_op.emit || !out_valid || pop);
  assign emit_fire  = q_rd && q_op.emit;
  assign empty      = !out_valid;

  always_comb begin
    shortest_length_next  = (length_count < shortest_length) ? length_count : shortest_length;
    longest_length_next   = (length_count > longest_length) ? length_count : longest_length;
    fewest_ambiguous_next = (ambiguous_tally < fewest_ambiguous) ? ambiguous_tally
                                                                 : fewest_ambiguous;
    most_ambiguous_next   = (ambiguous_tally > most_ambiguous) ? ambiguous_tally
                                                               : most_ambiguous;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_number    <= '0;
      length_count     <= '0;
      gc_tally         <= '0;
      at_tally         <= '0;
      ambiguous_tally  <= '0;
      anomalous_tally  <= '0;
      header_tally     <= '0;
      shortest_length  <= CNT_MAX;
      longest_length   <= '0;
      fewest_ambiguous <= CNT_MAX;
      most_ambiguous   <= '0;
    end else if (q_rd) begin
      if (q_op.emit) begin
        record_number    <= record_number + INDEX_WIDTH'(1);
        shortest_length  <= shortest_length_next;
        longest_length   <= longest_length_next;
        fewest_ambiguous <= fewest_ambiguous_next;
        most_ambiguous   <= most_ambiguous_next;
      end
      case (q_op.kind)
        OP_HDR: begin
          header_tally <= sat_inc(header_tally);
        end
        OP_SEQ: begin
          length_count <= sat_inc(length_count);
          case (q_op.cls)
            CLS_GC:  gc_tally <= sat_inc(gc_tally);
            CLS_AT:  at_tally <= sat_inc(at_tally);
            CLS_AMB: ambiguous_tally <= sat_inc(ambiguous_tally);
            default: anomalous_tally <= sat_inc(anomalous_tally);
          endcase
        end
        OP_OPEN: begin
          length_count    <= '0;
          gc_tally        <= '0;
          at_tally        <= '0;
          ambiguous_tally <= '0;
          anomalous_tally <= '0;
          header_tally    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      res.record_index    <= 16'(record_number);
      res.seq_length      <= 32'(length_count);
      res.gc_count        <= 32'(gc_tally);
      res.at_count        <= 32'(at_tally);
      res.ambiguous_count <= 32'(ambiguous_tally);
      res.anomalous_count <= 32'(anomalous_tally);
      res.header_length   <= 32'(header_tally);
      res.min_length      <= 32'(shortest_length_next);
      res.max_length      <= 32'(longest_length_next);
      res.min_ambiguous   <= 32'(fewest_ambiguous_next);
      res.max_ambiguous   <= 32'(most_ambiguous_next);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> (!out_valid || pop))
    else $error("result register overwritten before its transaction");

  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (shortest_length <= longest_length && fewest_ambiguous <= most_ambiguous))
    else $error("running extremes out of order after close");

  a_parts_within_length: assert property (@(posedge clk) disable iff (rst)
    ambiguous_tally <= length_count && anomalous_tally <= length_count)
    else $error("class tally exceeds sequence length");

endmodule

// ===== sv/fasta_record_composition_counter_core.sv =====
// Top level of the FASTA record composition counter.
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// input    | push / full          | mode, data_byte
// result   | empty / pop          | record_index, seq_length, counts, extremes
//
// One byte is taken every cycle while full is low; the front end decides the
// operation in the accepting cycle and the back end applies one op per cycle
// unless it stalls. A closing op passes the op queue, then its result waits in
// the result register; the back end stalls only on an op closing a record while
// it is held; full rises once the four-entry op queue fills behind it. Reset is
// synchronous and clears all but data storage at once; no clearing pass is needed.
`timescale 1ns / 1ps

module fasta_record_composition_counter_core
  import frcc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int INDEX_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] record_index,
  output logic [31:0] seq_length,
  output logic [31:0] gc_count,
  output logic [31:0] at_count,
  output logic [31:0] ambiguous_count,
  output logic [31:0] anomalous_count,
  output logic [31:0] header_length,
  output logic [31:0] min_length,
  output logic [31:0] max_length,
  output logic [31:0] min_ambiguous,
  output logic [31:0] max_ambiguous
);

  logic accept;
  logic op_valid;
  op_t  op;
  logic q_empty;
  logic q_rd;
  op_t  q_op;
  res_t res;

  assign accept = push && !full;

  frcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .data_byte (data_byte),
    .op_valid  (op_valid),
    .op        (op)
  );

  frcc_opq u_opq (
    .clk   (clk),
    .rst   (rst),
    .wr_en (op_valid),
    .wr_op (op),
    .full  (full),
    .rd_en (q_rd),
    .empty (q_empty),
    .rd_op (q_op)
  );

  frcc_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_op    (q_op),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign record_index    = res.record_index;
  assign seq_length      = res.seq_length;
  assign gc_count        = res.gc_count;
  assign at_count        = res.at_count;
  assign ambiguous_count = res.ambiguous_count;
  assign anomalous_count = res.anomalous_count;
  assign header_length   = res.header_length;
  assign min_length      = res.min_length;
  assign max_length      = res.max_length;
  assign min_ambiguous   = res.min_ambiguous;
  assign max_ambiguous   = res.max_ambiguous;

endmodule
